// ===== hdl/packet_filter_vm_execute_core_defines.svh =====
// Assertion macros used by the packet filter VM execute core.
`ifndef PACKET_FILTER_VM_EXECUTE_CORE_DEFINES_SVH
`define PACKET_FILTER_VM_EXECUTE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// ante holds -> cons holds in the same cycle
`define PFVM_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfvm assertion failed");
// ante holds -> cons holds in the next cycle
`define PFVM_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfvm assertion failed");
`else
`define PFVM_ASSERT_IMP(name, clk, rst, ante, cons)
`define PFVM_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/pfvm_pkg.sv =====
package pfvm_pkg;

  localparam int WORD_W = 32;
  localparam int SCRATCH_BYTES_DEF = 256;
  localparam int PACKET_BYTES_DEF = 2048;
  localparam int SCRATCH_LEN_W = 9;
  localparam logic [SCRATCH_LEN_W-1:0] SCRATCH_LEN_RST = 9'd256;

  localparam int IN_DATA_W = 80;
  localparam int IN_USER_W = 3;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;

  // bus commands
  localparam logic [2:0] CMD_START  = 3'd0;
  localparam logic [2:0] CMD_WR_PKT = 3'd1;
  localparam logic [2:0] CMD_EXEC   = 3'd2;
  localparam logic [2:0] CMD_RD_PKT = 3'd3;
  localparam logic [2:0] CMD_WR_SCR = 3'd4;
  localparam logic [2:0] CMD_RD_SCR = 3'd5;

  // opcodes
  localparam logic [3:0] OP_EXIT = 4'd0;
  localparam logic [3:0] OP_COPY = 4'd1;
  localparam logic [3:0] OP_NEWP = 4'd2;
  localparam logic [3:0] OP_MOVW = 4'd3;
  localparam logic [3:0] OP_ADD  = 4'd4;
  localparam logic [3:0] OP_SUB  = 4'd5;
  localparam logic [3:0] OP_MUL  = 4'd6;
  localparam logic [3:0] OP_DIV  = 4'd7;
  localparam logic [3:0] OP_AND  = 4'd8;
  localparam logic [3:0] OP_OR   = 4'd9;
  localparam logic [3:0] OP_XOR  = 4'd10;
  localparam logic [3:0] OP_SHL  = 4'd11;
  localparam logic [3:0] OP_SHR  = 4'd12;
  localparam logic [3:0] OP_NOP0 = 4'd13;
  localparam logic [3:0] OP_NOP1 = 4'd14;
  localparam logic [3:0] OP_STOP = 4'd15;

  // mode codes
  localparam logic [1:0] MODE_IMM = 2'd0;
  localparam logic [1:0] MODE_X   = 2'd1;
  localparam logic [1:0] MODE_Y   = 2'd2;
  localparam logic [1:0] MODE_M2P = 2'd0;
  localparam logic [1:0] MODE_P2M = 2'd1;
  localparam logic [1:0] MODE_PKT = 2'd0;

  // word move operands
  localparam logic [3:0] MV_A    = 4'd0;
  localparam logic [3:0] MV_X    = 4'd1;
  localparam logic [3:0] MV_Y    = 4'd2;
  localparam logic [3:0] MV_IMM  = 4'd3;
  localparam logic [3:0] MV_NOTA = 4'd4;
  localparam logic [3:0] MV_NEGA = 4'd5;
  localparam logic [3:0] MV_MN   = 4'd6;
  localparam logic [3:0] MV_PN   = 4'd7;
  localparam logic [3:0] MV_MNX  = 4'd8;
  localparam logic [3:0] MV_PNX  = 4'd9;
  localparam logic [3:0] MV_IPHP = 4'd10;
  localparam logic [3:0] MV_IPHM = 4'd11;

  // start..start+cnt-1 lies inside [0, lim) without wrapping
  function automatic logic span_ok(input logic [WORD_W-1:0] start,
                                   input logic [WORD_W-1:0] cnt,
                                   input logic [WORD_W-1:0] lim);
    logic [WORD_W:0] last;
    begin
      last = {1'b0, start} + {1'b0, cnt} - {{WORD_W{1'b0}}, 1'b1};
      return (cnt != '0) && !last[WORD_W] && (last[WORD_W-1:0] < lim);
    end
  endfunction

endpackage

// ===== hdl/pfvm_ram.sv =====
module pfvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/pfvm_div.sv =====
module pfvm_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pfvm_pkg::WORD_W-1:0] dividend,
  input  logic [pfvm_pkg::WORD_W-1:0] divisor,
  output logic                      busy,
  output logic                      done,
  output logic [pfvm_pkg::WORD_W-1:0] quot
);
  import pfvm_pkg::*;

  localparam int CNT_W = $clog2(WORD_W);

  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] dsr;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W:0]   diff;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem, quot[WORD_W-1]};
  assign diff   = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quot <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        rem  <= diff[WORD_W] ? rem_sh[WORD_W-1:0] : diff[WORD_W-1:0];
        quot <= {quot[WORD_W-2:0], !diff[WORD_W]};
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/packet_filter_vm_execute_core.sv =====
// Packet filter VM execute core.
// Input beats arrive on s_tvalid/s_tready with the command in s_tuser; every
// accepted beat gives exactly one result beat on m_tvalid/m_tready. The scratch
// length register is written through cfg_valid/cfg_ready/cfg_data; the user must
// write it only while the core is idle, which the core does not enforce. Packet
// and scratch bytes live in two byte-wide RAMs with a registered read, so read
// data is always used in a step after the one that gave the address.
// Path from accept to result: start, byte writes, register ops, exit and word
// moves between registers go from S_EXEC to S_DONE; byte reads pass S_RD;
// a word move touching memory reads in S_MW_SRC and/or writes in S_MW_DST;
// a divide waits in S_DIV on the 32-step divider; a copy of A bytes streams
// through S_COPY one byte per cycle.
// One item is in flight at a time; s_tready is high only while idle. A
// finished result sits in the output register while the next beat is taken,
// and a stalled receiver holds the core in its final step until m_tready.
// Reset clears A, X, Y, halt, packet length and the output valid, and sets the
// scratch length to 256; RAM contents are undefined until written.
module packet_filter_vm_execute_core #(
  parameter int SCRATCH_BYTES = pfvm_pkg::SCRATCH_BYTES_DEF,
  parameter int PACKET_BYTES  = pfvm_pkg::PACKET_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // byte_index, byte_value, packet_length, opcode, mode, move_source,
  // move_dest, immediate, 3 zero pad bits
  input  logic [pfvm_pkg::IN_DATA_W-1:0]      s_tdata,
  // cmd
  input  logic [pfvm_pkg::IN_USER_W-1:0]      s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // read_data, acc_value
  output logic [pfvm_pkg::OUT_DATA_W-1:0]     m_tdata,
  // halted, new_program_request
  output logic [pfvm_pkg::OUT_USER_W-1:0]     m_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pfvm_pkg::SCRATCH_LEN_W-1:0]  cfg_data
);
  `include "packet_filter_vm_execute_core_defines.svh"
  import pfvm_pkg::*;

  localparam int SA_W  = $clog2(SCRATCH_BYTES);
  localparam int PA_W  = $clog2(PACKET_BYTES);
  localparam int PTR_W = (SA_W > PA_W) ? SA_W : PA_W;
  localparam int CNT_W = PTR_W + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_RD, S_COPY, S_DIV, S_MW_SRC, S_MW_DST, S_DONE
  } state_t;

  state_t state;

  // machine state
  logic [WORD_W-1:0]        acc, idx_x, idx_y;
  logic                     halt;
  logic [11:0]              plen;
  logic [SCRATCH_LEN_W-1:0] scr_len;

  // latched item
  logic [2:0]        cmd_q;
  logic [10:0]       bidx_q;
  logic [7:0]        bval_q;
  logic [11:0]       blen_q;
  logic [3:0]        op_q;
  logic [1:0]        mode_q;
  logic [3:0]        src_q, dst_q;
  logic [WORD_W-1:0] imm_q;

  // sequencer working registers
  logic [PTR_W-1:0]  src_ptr, dst_ptr;
  logic              src_pkt, dst_pkt, iph;
  logic [CNT_W-1:0]  cnt, wcnt;
  logic              rvld;
  logic [WORD_W-1:0] word;
  logic [7:0]        rd_q;
  logic              req_q;

  // RAM ports
  logic [PTR_W-1:0] rd_addr, wr_addr;
  logic [7:0]       wr_data;
  logic             pk_we, sc_we;
  logic [7:0]       pk_q, sc_q, src_q8;

  // divider
  logic              div_start, div_busy, div_done;
  logic [WORD_W-1:0] div_quot;

  // decode helpers
  logic [WORD_W-1:0] idx32, mem_lim, pkt_lim, rhs, nx, alu;
  logic [WORD_W-1:0] s_addr, d_addr, s_lim, d_lim, s_val, lim32;
  logic              idx_in_pkt, idx_in_scr, s_ok, d_ok;
  logic              s_mem, d_mem, mv_nop, s_pkt_c, d_pkt_c, iph_c;
  logic [CNT_W-1:0]  acc_cnt;
  logic [2:0]        nbytes;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign idx32      = {{(WORD_W-11){1'b0}}, bidx_q};
  assign idx_in_pkt = idx32 < WORD_W'(PACKET_BYTES);
  assign idx_in_scr = idx32 < WORD_W'(SCRATCH_BYTES);
  assign mem_lim    = ({23'd0, scr_len} < WORD_W'(SCRATCH_BYTES)) ?
                      {23'd0, scr_len} : WORD_W'(SCRATCH_BYTES);
  assign pkt_lim    = {20'd0, plen};
  assign lim32      = WORD_W'(PACKET_BYTES);
  assign acc_cnt    = acc[CNT_W-1:0];

  assign rhs = (mode_q == MODE_IMM) ? imm_q : ((mode_q == MODE_X) ? idx_x : idx_y);
  assign nx  = imm_q + idx_x;

  // ALU for everything but divide
  always_comb begin
    case (op_q)
      OP_ADD:  alu = acc + rhs;
      OP_SUB:  alu = acc - rhs;
      OP_MUL:  alu = acc * rhs;
      OP_AND:  alu = acc & rhs;
      OP_OR:   alu = acc | rhs;
      OP_XOR:  alu = acc ^ rhs;
      OP_SHL:  alu = (rhs >= WORD_W'(WORD_W)) ? '0 : (acc << rhs[4:0]);
      default: alu = (rhs >= WORD_W'(WORD_W)) ? '0 : (acc >> rhs[4:0]);
    endcase
  end

  // word move operand decode
  assign mv_nop  = (src_q == dst_q) || (src_q > MV_IPHM) || (dst_q > MV_PNX) ||
                   (dst_q == MV_IMM) || (dst_q == MV_NOTA) || (dst_q == MV_NEGA);
  assign s_mem   = (src_q >= MV_MN);
  assign d_mem   = (dst_q >= MV_MN);
  assign iph_c   = (src_q == MV_IPHP) || (src_q == MV_IPHM);
  assign s_pkt_c = (src_q == MV_PN) || (src_q == MV_PNX) || (src_q == MV_IPHP);
  assign d_pkt_c = (dst_q == MV_PN) || (dst_q == MV_PNX);
  assign s_addr  = iph_c ? idx_x : ((src_q >= MV_MNX) ? nx : imm_q);
  assign d_addr  = (dst_q >= MV_MNX) ? nx : imm_q;
  assign s_lim   = s_pkt_c ? pkt_lim : mem_lim;
  assign d_lim   = d_pkt_c ? pkt_lim : mem_lim;
  assign s_ok    = span_ok(s_addr, iph_c ? WORD_W'(1) : WORD_W'(4), s_lim);
  assign d_ok    = span_ok(d_addr, WORD_W'(4), d_lim);
  assign nbytes  = iph ? 3'd1 : 3'd4;

  always_comb begin
    case (src_q)
      MV_A:    s_val = acc;
      MV_X:    s_val = idx_x;
      MV_Y:    s_val = idx_y;
      MV_IMM:  s_val = imm_q;
      MV_NOTA: s_val = ~acc;
      default: s_val = '0 - acc;
    endcase
  end

  assign src_q8 = src_pkt ? pk_q : sc_q;

  // RAM port control
  always_comb begin
    rd_addr = '0;
    wr_addr = '0;
    wr_data = bval_q;
    pk_we   = 1'b0;
    sc_we   = 1'b0;
    unique case (state)
      S_EXEC: begin
        rd_addr = idx32[PTR_W-1:0];
        wr_addr = idx32[PTR_W-1:0];
        pk_we   = (cmd_q == CMD_WR_PKT) && idx_in_pkt;
        sc_we   = (cmd_q == CMD_WR_SCR) && idx_in_scr;
      end
      S_COPY: begin
        rd_addr = src_ptr + cnt[PTR_W-1:0];
        wr_addr = dst_ptr + wcnt[PTR_W-1:0];
        wr_data = src_q8;
        pk_we   = rvld && !src_pkt;
        sc_we   = rvld && src_pkt;
      end
      S_MW_SRC: begin
        rd_addr = src_ptr + cnt[PTR_W-1:0];
      end
      S_MW_DST: begin
        wr_addr = dst_ptr + cnt[PTR_W-1:0];
        wr_data = word[WORD_W-1:WORD_W-8];
        pk_we   = dst_pkt;
        sc_we   = !dst_pkt;
      end
      default: ;
    endcase
  end

  pfvm_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_pkt_ram (
    .clk  (clk),
    .we   (pk_we),
    .waddr(wr_addr[PA_W-1:0]),
    .wdata(wr_data),
    .raddr(rd_addr[PA_W-1:0]),
    .rdata(pk_q)
  );

  pfvm_ram #(.WIDTH(8), .DEPTH(SCRATCH_BYTES)) u_scr_ram (
    .clk  (clk),
    .we   (sc_we),
    .waddr(wr_addr[SA_W-1:0]),
    .wdata(wr_data),
    .raddr(rd_addr[SA_W-1:0]),
    .rdata(sc_q)
  );

  assign div_start = (state == S_EXEC) && (cmd_q == CMD_EXEC) && !halt &&
                     (op_q == OP_DIV) && (mode_q != 2'd3) && (rhs != '0);

  pfvm_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(acc),
    .divisor (rhs),
    .busy    (div_busy),
    .done    (div_done),
    .quot    (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      acc      <= '0;
      idx_x    <= '0;
      idx_y    <= '0;
      halt     <= 1'b0;
      plen     <= '0;
      scr_len  <= SCRATCH_LEN_RST;
      m_tvalid <= 1'b0;
      rvld     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        scr_len <= cfg_data;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      rvld <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_q  <= s_tuser;
            bidx_q <= s_tdata[10:0];
            bval_q <= s_tdata[18:11];
            blen_q <= s_tdata[30:19];
            op_q   <= s_tdata[34:31];
            mode_q <= s_tdata[36:35];
            src_q  <= s_tdata[40:37];
            dst_q  <= s_tdata[44:41];
            imm_q  <= s_tdata[76:45];
            state  <= S_EXEC;
          end
        end

        S_EXEC: begin
          rd_q  <= '0;
          req_q <= 1'b0;
          state <= S_DONE;
          unique case (cmd_q)
            CMD_START: begin
              acc   <= '0;
              idx_x <= '0;
              idx_y <= '0;
              halt  <= 1'b0;
              plen  <= ({20'd0, blen_q} > lim32) ? lim32[11:0] : blen_q;
            end
            CMD_RD_PKT: if (idx_in_pkt) state <= S_RD;
            CMD_RD_SCR: if (idx_in_scr) state <= S_RD;
            CMD_EXEC: begin
              if (!halt) begin
                unique case (op_q) inside
                  OP_EXIT, OP_STOP: halt <= 1'b1;
                  OP_COPY: begin
                    if (mode_q > MODE_P2M) begin
                      acc <= '0;
                    end else if (!span_ok(idx_x, acc,
                                          (mode_q == MODE_P2M) ? pkt_lim : mem_lim) ||
                                 !span_ok(idx_y, acc,
                                          (mode_q == MODE_M2P) ? pkt_lim : mem_lim)) begin
                      acc <= '0;
                    end else begin
                      src_pkt <= (mode_q == MODE_P2M);
                      src_ptr <= idx_x[PTR_W-1:0];
                      dst_ptr <= idx_y[PTR_W-1:0];
                      cnt     <= '0;
                      wcnt    <= '0;
                      state   <= S_COPY;
                    end
                  end
                  OP_NEWP: begin
                    if (mode_q > 2'd1 ||
                        !span_ok(idx_x, acc,
                                 (mode_q == MODE_PKT) ? pkt_lim : mem_lim)) begin
                      acc <= '0;
                    end else begin
                      req_q <= 1'b1;
                      halt  <= 1'b1;
                    end
                  end
                  OP_MOVW: begin
                    if (mv_nop) begin
                      state <= S_DONE;
                    end else if (s_mem) begin
                      if (s_ok && (!d_mem || d_ok)) begin
                        src_ptr <= s_addr[PTR_W-1:0];
                        src_pkt <= s_pkt_c;
                        iph     <= iph_c;
                        dst_ptr <= d_addr[PTR_W-1:0];
                        dst_pkt <= d_pkt_c;
                        cnt     <= '0;
                        wcnt    <= '0;
                        state   <= S_MW_SRC;
                      end
                    end else if (d_mem) begin
                      if (d_ok) begin
                        word    <= s_val;
                        dst_ptr <= d_addr[PTR_W-1:0];
                        dst_pkt <= d_pkt_c;
                        cnt     <= '0;
                        state   <= S_MW_DST;
                      end
                    end else begin
                      unique case (dst_q)
                        MV_A:    acc   <= s_val;
                        MV_X:    idx_x <= s_val;
                        default: idx_y <= s_val;
                      endcase
                    end
                  end
                  OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_XOR,
                  OP_SHL, OP_SHR: begin
                    if (mode_q == 2'd3) begin
                      halt <= 1'b1;
                    end else if (op_q == OP_DIV) begin
                      if (rhs == '0) acc <= '0;
                      else state <= S_DIV;
                    end else begin
                      acc <= alu;
                    end
                  end
                  default: ;
                endcase
              end
            end
            default: ;
          endcase
        end

        S_RD: begin
          rd_q  <= (cmd_q == CMD_RD_PKT) ? pk_q : sc_q;
          state <= S_DONE;
        end

        // stream bytes: read one per cycle, write it the cycle after
        S_COPY: begin
          if (cnt != acc_cnt) begin
            cnt  <= cnt + 1'b1;
            rvld <= 1'b1;
          end
          if (rvld) begin
            wcnt <= wcnt + 1'b1;
            if (wcnt == acc_cnt - 1'b1) begin
              acc   <= WORD_W'(1);
              state <= S_DONE;
            end
          end
        end

        S_DIV: begin
          if (div_done) begin
            acc   <= div_quot;
            state <= S_DONE;
          end
        end

        // gather the big-endian source word
        S_MW_SRC: begin
          if (cnt[2:0] != nbytes) begin
            cnt  <= cnt + 1'b1;
            rvld <= 1'b1;
          end
          if (rvld) begin
            word <= {word[WORD_W-9:0], src_q8};
            wcnt <= wcnt + 1'b1;
            if (wcnt[2:0] == nbytes - 3'd1) begin
              cnt <= '0;
              if (d_mem) begin
                state <= S_MW_DST;
                if (iph) word <= {26'd0, src_q8[3:0], 2'b00};
              end else begin
                state <= S_DONE;
                unique case (dst_q)
                  MV_A: acc <= iph ? {26'd0, src_q8[3:0], 2'b00}
                                   : {word[WORD_W-9:0], src_q8};
                  MV_X: idx_x <= iph ? {26'd0, src_q8[3:0], 2'b00}
                                     : {word[WORD_W-9:0], src_q8};
                  default: idx_y <= iph ? {26'd0, src_q8[3:0], 2'b00}
                                        : {word[WORD_W-9:0], src_q8};
                endcase
              end
            end
          end
        end

        S_MW_DST: begin
          word <= {word[WORD_W-9:0], 8'd0};
          cnt  <= cnt + 1'b1;
          if (cnt[2:0] == 3'd3) state <= S_DONE;
        end

        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {acc, rd_q};
            m_tuser  <= {req_q, halt};
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `PFVM_ASSERT_IMP(a_req_halts, clk, rst, m_tvalid && m_tuser[1], m_tuser[0])
  `PFVM_ASSERT_IMP(a_div_in_state, clk, rst, div_busy, state == S_DIV)
  `PFVM_ASSERT_NEXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready)

endmodule

// ===== dv/packet_filter_vm_execute_core_test.sv =====
`timescale 1ns / 1ps

module packet_filter_vm_execute_core_test;
  import pfvm_pkg::*;

  // bus commands with no function in the core
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam int PKT_BYTES = PACKET_BYTES_DEF;
  localparam int SCR_BYTES = SCRATCH_BYTES_DEF;
  localparam int PKT_FILL = 512;        // packet bytes preloaded; random packets stay inside
  localparam int DRAIN_CYCLES = 60;     // longer than a divide plus output slack
  localparam int STALL_LIMIT = 30000;   // cycles with no beat anywhere

  typedef struct packed {
    logic [2:0]  cmd;
    logic [10:0] byte_index;
    logic [7:0]  byte_value;
    logic [11:0] packet_length;
    logic [3:0]  opcode;
    logic [1:0]  mode;
    logic [3:0]  move_source;
    logic [3:0]  move_dest;
    logic [31:0] immediate;
  } vm_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [31:0] acc_value;
    logic        halted;
    logic        new_program_request;
  } vm_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;   // byte_index, byte_value, packet_length, opcode, mode,
                                        // move_source, move_dest, immediate, zero pad
  logic [IN_USER_W-1:0] s_tuser = '0;   // cmd
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;       // read_data, acc_value
  logic [OUT_USER_W-1:0] m_tuser;       // halted, new_program_request
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SCRATCH_LEN_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  packet_filter_vm_execute_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // VM shadow state, updated when an input beat is taken
  // ---------------------------------------------------------------------------
  logic [31:0] vm_a, vm_x, vm_y;
  logic        vm_halt;
  logic [11:0] vm_plen;
  logic [8:0]  vm_scr_len = SCRATCH_LEN_RST;
  logic [7:0]  pkt_mem [PKT_BYTES];
  logic [7:0]  scr_mem [SCR_BYTES];

  vm_item_t   item_q [$];      // beats waiting for the driver
  vm_result_t result_q [$];    // predicted output beats, oldest first
  int errors = 0;
  int items_in = 0, results_out = 0, cfg_writes = 0;
  int n_copy_ok = 0, n_newprog = 0, n_movw_mem = 0;
  bit no_idle = 1'b0;          // phase with no idle gaps on either side

  function automatic logic span_chk(logic [31:0] start, logic [31:0] cnt, logic [31:0] lim);
    logic [32:0] last;
    last = {1'b0, start} + {1'b0, cnt} - 33'd1;
    return (cnt != 0) && !last[32] && (last[31:0] < lim);
  endfunction

  function automatic logic [31:0] scr_lim();
    return (vm_scr_len < SCR_BYTES) ? 32'(vm_scr_len) : 32'(SCR_BYTES);
  endfunction

  function automatic logic [31:0] area_lim(logic pkt);
    return pkt ? 32'(vm_plen) : scr_lim();
  endfunction

  function automatic logic [7:0] mem_rd(logic pkt, logic [31:0] i);
    return pkt ? pkt_mem[i[10:0]] : scr_mem[i[7:0]];
  endfunction

  function automatic void mem_wr(logic pkt, logic [31:0] i, logic [7:0] v);
    if (pkt) pkt_mem[i[10:0]] = v;
    else scr_mem[i[7:0]] = v;
  endfunction

  // word move; any failed check leaves the state alone
  function automatic void word_move(logic [3:0] src, logic [3:0] dst, logic [31:0] n);
    logic [31:0] v, i;
    logic pkt;
    int k;
    if (src == dst || src > MV_IPHM || dst > MV_PNX || (dst >= MV_IMM && dst <= MV_NEGA))
      return;
    case (src)
      MV_A:    v = vm_a;
      MV_X:    v = vm_x;
      MV_Y:    v = vm_y;
      MV_IMM:  v = n;
      MV_NOTA: v = ~vm_a;
      MV_NEGA: v = 32'd0 - vm_a;
      MV_MN, MV_PN, MV_MNX, MV_PNX: begin
        i = (src >= MV_MNX) ? n + vm_x : n;
        pkt = (src == MV_PN || src == MV_PNX);
        if (!span_chk(i, 32'd4, area_lim(pkt))) return;
        for (k = 0; k < 4; k++) v = {v[23:0], mem_rd(pkt, i + k)};
        n_movw_mem++;
      end
      default: begin
        pkt = (src == MV_IPHP);
        if (!span_chk(vm_x, 32'd1, area_lim(pkt))) return;
        v = 32'(mem_rd(pkt, vm_x) & 8'h0f) << 2;
      end
    endcase
    case (dst)
      MV_A: vm_a = v;
      MV_X: vm_x = v;
      MV_Y: vm_y = v;
      default: begin
        i = (dst >= MV_MNX) ? n + vm_x : n;
        pkt = (dst == MV_PN || dst == MV_PNX);
        if (!span_chk(i, 32'd4, area_lim(pkt))) return;
        for (k = 0; k < 4; k++) mem_wr(pkt, i + k, v[31 - 8 * k -: 8]);
        n_movw_mem++;
      end
    endcase
  endfunction

  // one instruction; returns the new-program flag
  function automatic logic run_insn(vm_item_t it);
    logic [31:0] r;
    logic pkt_src;
    int k;
    if (vm_halt) return 1'b0;
    case (it.opcode)
      OP_EXIT, OP_STOP: vm_halt = 1'b1;
      OP_COPY: begin
        if (it.mode > MODE_P2M) vm_a = 0;
        else begin
          pkt_src = (it.mode == MODE_P2M);
          if (!span_chk(vm_x, vm_a, area_lim(pkt_src)) || !span_chk(vm_y, vm_a, area_lim(!pkt_src)))
            vm_a = 0;
          else begin
            for (k = 0; k < vm_a; k++) mem_wr(!pkt_src, vm_y + k, mem_rd(pkt_src, vm_x + k));
            vm_a = 1;
            n_copy_ok++;
          end
        end
      end
      OP_NEWP: begin
        if (it.mode > 2'd1 || !span_chk(vm_x, vm_a, area_lim(it.mode == MODE_PKT))) vm_a = 0;
        else begin
          vm_halt = 1'b1;
          n_newprog++;
          return 1'b1;
        end
      end
      OP_MOVW: word_move(it.move_source, it.move_dest, it.immediate);
      OP_NOP0, OP_NOP1: ;
      default: begin
        if (it.mode > MODE_Y) vm_halt = 1'b1;
        else begin
          r = (it.mode == MODE_IMM) ? it.immediate : (it.mode == MODE_X ? vm_x : vm_y);
          case (it.opcode)
            OP_ADD: vm_a = vm_a + r;
            OP_SUB: vm_a = vm_a - r;
            OP_MUL: vm_a = vm_a * r;
            OP_DIV: vm_a = (r == 0) ? 32'd0 : vm_a / r;
            OP_AND: vm_a = vm_a & r;
            OP_OR:  vm_a = vm_a | r;
            OP_XOR: vm_a = vm_a ^ r;
            OP_SHL: vm_a = (r >= 32) ? 32'd0 : vm_a << r;
            default: vm_a = (r >= 32) ? 32'd0 : vm_a >> r;
          endcase
        end
      end
    endcase
    return 1'b0;
  endfunction

  function automatic vm_result_t vm_step(vm_item_t it);
    vm_result_t res;
    res = '0;
    case (it.cmd)
      CMD_START: begin
        vm_a = 0; vm_x = 0; vm_y = 0; vm_halt = 1'b0;
        vm_plen = (it.packet_length > PKT_BYTES) ? 12'(PKT_BYTES) : it.packet_length;
      end
      CMD_WR_PKT: pkt_mem[it.byte_index] = it.byte_value;
      CMD_EXEC:   res.new_program_request = run_insn(it);
      CMD_RD_PKT: res.read_data = pkt_mem[it.byte_index];
      CMD_WR_SCR: if (it.byte_index < SCR_BYTES) scr_mem[it.byte_index[7:0]] = it.byte_value;
      CMD_RD_SCR: if (it.byte_index < SCR_BYTES) res.read_data = scr_mem[it.byte_index[7:0]];
      default: ;
    endcase
    res.acc_value = vm_a;
    res.halted = vm_halt;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic vm_item_t bus_beat(logic [2:0] cmd, logic [10:0] idx, logic [7:0] val,
                                        logic [11:0] plen);
    vm_item_t it;
    it = '0;
    it.cmd = cmd; it.byte_index = idx; it.byte_value = val; it.packet_length = plen;
    return it;
  endfunction

  function automatic vm_item_t exec_beat(logic [3:0] op, logic [1:0] mode, logic [3:0] src,
                                         logic [3:0] dst, logic [31:0] n);
    vm_item_t it;
    it = '0;
    it.cmd = CMD_EXEC; it.opcode = op; it.mode = mode;
    it.move_source = src; it.move_dest = dst; it.immediate = n;
    return it;
  endfunction

  function automatic logic [31:0] rand_imm();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(0, 40);
    if (r < 7) return $urandom_range(0, 2100);
    if (r < 8) return 32'hffff_ffff - $urandom_range(0, 8);
    return $urandom;
  endfunction

  function automatic vm_item_t rand_beat();
    vm_item_t it;
    int r;
    it = '0;
    it.byte_index = 11'($urandom);
    it.byte_value = 8'($urandom);
    it.packet_length = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(301, PKT_FILL)) :
                                                     12'($urandom_range(0, 300));
    it.move_source = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 11));
    it.move_dest = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 9));
    it.mode = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    it.immediate = rand_imm();
    // well-formed packets dominate: occasional start, mostly instructions
    r = $urandom_range(0, 99);
    if (r < 6) it.cmd = CMD_START;
    else if (r < 16) it.cmd = CMD_WR_PKT;
    else if (r < 22) it.cmd = CMD_RD_PKT;
    else if (r < 28) it.cmd = CMD_WR_SCR;
    else if (r < 34) it.cmd = CMD_RD_SCR;
    else if (r < 36) it.cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE6 : CMD_SPARE7;
    else it.cmd = CMD_EXEC;
    if (it.cmd == CMD_RD_SCR || it.cmd == CMD_WR_SCR)
      if ($urandom_range(0, 3) != 0) it.byte_index = 11'($urandom_range(0, SCR_BYTES - 1));
    // packet reads stay in the preloaded bytes
    if (it.cmd == CMD_RD_PKT) it.byte_index = 11'($urandom_range(0, PKT_FILL - 1));
    r = $urandom_range(0, 99);
    if (r < 2) it.opcode = OP_EXIT;
    else if (r < 4) it.opcode = OP_STOP;
    else if (r < 16) it.opcode = OP_COPY;
    else if (r < 21) it.opcode = OP_NEWP;
    else if (r < 56) it.opcode = OP_MOVW;
    else if (r < 60) it.opcode = ($urandom_range(0, 1) != 0) ? OP_NOP0 : OP_NOP1;
    else it.opcode = 4'($urandom_range(OP_ADD, OP_SHR));
    return it;
  endfunction

  function automatic int rand_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 19);
    if (r < 13) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one beat at a time from item_q
  // ---------------------------------------------------------------------------
  vm_item_t cur_item;
  int src_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        result_q.push_back(vm_step(cur_item));
        items_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_tvalid <= 1'b0;
        end else if (item_q.size() > 0) begin
          cur_item = item_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= cur_item.cmd;
          s_tdata <= {3'b000, cur_item.immediate, cur_item.move_dest, cur_item.move_source,
                      cur_item.mode, cur_item.opcode, cur_item.packet_length,
                      cur_item.byte_value, cur_item.byte_index};
          src_gap <= rand_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random backpressure, field-by-field compare
  // ---------------------------------------------------------------------------
  int sink_gap = 0;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("%0t ERROR beat %0d %s: got %0h want %0h", $realtime, results_out, what, got, want);
  endtask

  always @(posedge clk) begin
    vm_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t ERROR unexpected result beat %0h", $realtime, m_tdata);
        end else begin
          want = result_q.pop_front();
          if (m_tdata[7:0] !== want.read_data)
            report_mismatch("read_data", m_tdata[7:0], want.read_data);
          if (m_tdata[39:8] !== want.acc_value)
            report_mismatch("acc_value", m_tdata[39:8], want.acc_value);
          if (m_tuser[0] !== want.halted)
            report_mismatch("halted", m_tuser[0], want.halted);
          if (m_tuser[1] !== want.new_program_request)
            report_mismatch("new_program_request", m_tuser[1], want.new_program_request);
        end
        results_out++;
      end
      if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        sink_gap <= rand_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog on cycles with no beat on any channel
  // ---------------------------------------------------------------------------
  int quiet = 0;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else if (quiet >= STALL_LIMIT) begin
      $display("packet_filter_vm_execute_core_test: done, errors");
      $finish;
    end else
      quiet <= quiet + 1;
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  task automatic drain();
    wait (item_q.size() == 0 && !s_tvalid && result_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_scratch_len(logic [8:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    vm_scr_len = v;
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [8:0] scr_len_set [6] = '{9'd256, 9'd0, 9'd511, 9'd37, 9'd300, 9'd1};
    int i, p;
    vm_a = 0; vm_x = 0; vm_y = 0; vm_halt = 1'b0; vm_plen = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // preload the packet area in use and all of scratch so every read sees a written byte
    for (i = 0; i < PKT_FILL; i++)
      item_q.push_back(bus_beat(CMD_WR_PKT, 11'(i), 8'($urandom), 12'd0));
    item_q.push_back(bus_beat(CMD_WR_PKT, 11'h7ff, 8'($urandom), 12'd0));
    for (i = 0; i < SCR_BYTES; i++)
      item_q.push_back(bus_beat(CMD_WR_SCR, 11'(i), 8'($urandom), 12'd0));

    // directed corners
    item_q.push_back(bus_beat(CMD_START, 0, 0, 12'hfff));           // length saturates
    item_q.push_back(bus_beat(CMD_RD_PKT, 11'h7ff, 0, 0));
    item_q.push_back(bus_beat(CMD_RD_SCR, 11'h7ff, 0, 0));          // beyond scratch reads 0
    item_q.push_back(bus_beat(CMD_WR_SCR, 11'h7ff, 8'hff, 0));      // ignored
    item_q.push_back(bus_beat(CMD_SPARE6, 0, 0, 0));
    item_q.push_back(bus_beat(CMD_SPARE7, 11'h7ff, 8'hff, 12'hfff));
    item_q.push_back(exec_beat(OP_MOVW, 0, MV_IMM, MV_A, 32'd8));
    item_q.push_back(exec_beat(OP_MOVW, 0, MV_IMM, MV_X, 32'd4));
    item_q.push_back(exec_beat(OP_MOVW, 0, MV_IMM, MV_Y, 32'd100));
    item_q.push_back(exec_beat(OP_COPY, MODE_P2M, 0, 0, 0));        // copy passes, A = 1
    item_q.push_back(exec_beat(OP_COPY, 2'd2, 0, 0, 0));            // bad mode, A = 0
    item_q.push_back(exec_beat(OP_DIV, MODE_IMM, 0, 0, 32'd0));     // divide by zero
    item_q.push_back(exec_beat(OP_SUB, MODE_IMM, 0, 0, 32'd1));
    item_q.push_back(exec_beat(OP_SHL, MODE_IMM, 0, 0, 32'd32));    // shift out of range
    item_q.push_back(exec_beat(OP_MOVW, 0, MV_NEGA, MV_MNX, 32'hffff_fffc)); // address wraps to 0, move succeeds
    item_q.push_back(exec_beat(OP_MOVW, 0, MV_IPHP, MV_Y, 0));
    item_q.push_back(exec_beat(OP_MOVW, 0, MV_A, MV_A, 0));         // same operand
    item_q.push_back(exec_beat(OP_MOVW, 0, MV_X, MV_IMM, 0));       // bad destination
    item_q.push_back(exec_beat(OP_MOVW, 0, 4'd15, MV_A, 0));        // bad source
    item_q.push_back(exec_beat(OP_ADD, 2'd3, 0, 0, 0));             // math mode 3 halts
    item_q.push_back(exec_beat(OP_ADD, MODE_IMM, 0, 0, 32'd5));     // ignored while halted
    item_q.push_back(bus_beat(CMD_START, 0, 0, 12'd64));
    item_q.push_back(exec_beat(OP_MOVW, 0, MV_IMM, MV_A, 32'd16));
    item_q.push_back(exec_beat(OP_NEWP, MODE_PKT, 0, 0, $urandom)); // request flagged
    item_q.push_back(bus_beat(CMD_START, 0, 0, 12'd2048));
    item_q.push_back(exec_beat(OP_EXIT, 0, 0, 0, 0));

    // random phases at several scratch lengths, the third and sixth at full rate
    for (p = 0; p < 6; p++) begin
      write_scratch_len(scr_len_set[p]);
      no_idle = (p % 3 == 2);
      for (i = 0; i < 100; i++) item_q.push_back(rand_beat());
    end

    drain();
    $display("covered %0d input beats, %0d results, %0d scratch length writes",
             items_in, results_out, cfg_writes);
    $display("good copies %0d, program requests %0d, memory word moves %0d",
             n_copy_ok, n_newprog, n_movw_mem);
    if (errors == 0)
      $display("packet_filter_vm_execute_core_test: done, clean");
    else
      $display("packet_filter_vm_execute_core_test: done, errors");
    $finish;
  end

endmodule

// ===== packet_filter_vm_execute_core.f =====
+incdir+hdl
hdl/pfvm_pkg.sv
hdl/pfvm_ram.sv
hdl/pfvm_div.sv
hdl/packet_filter_vm_execute_core.sv
dv/packet_filter_vm_execute_core_test.sv
